>>> src/mpfd_pkg.sv
// Shared constants, channel layout and digit glyph table for the page-mode framebuffer.
`default_nettype none
package mpfd_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int GLYPH_COLS     = 5;

    // Input item layout (tdata)
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;

    localparam logic [2:0] ACT_PIXEL = 3'd0;
    localparam logic [2:0] ACT_RECT  = 3'd1;
    localparam logic [2:0] ACT_DIGIT = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    localparam logic [7:0] CODE_ZERO = 8'd48;
    localparam logic [7:0] CODE_NINE = 8'd57;

    function automatic logic [7:0] digit_column(input logic [3:0] digit, input logic [2:0] col);
        logic [39:0] glyph;
        case (digit)
            4'd0:    glyph = 40'h3E_45_49_51_3E;
            4'd1:    glyph = 40'h00_40_7F_42_00;
            4'd2:    glyph = 40'h46_49_51_61_42;
            4'd3:    glyph = 40'h31_4B_45_41_21;
            4'd4:    glyph = 40'h10_7F_12_14_18;
            4'd5:    glyph = 40'h39_45_45_45_27;
            4'd6:    glyph = 40'h30_49_49_4A_3C;
            4'd7:    glyph = 40'h03_05_09_71_01;
            4'd8:    glyph = 40'h36_49_49_49_36;
            4'd9:    glyph = 40'h1E_29_49_49_06;
            default: glyph = 40'h0;
        endcase
        // column 0 sits in the low byte
        case (col)
            3'd0:    digit_column = glyph[7:0];
            3'd1:    digit_column = glyph[15:8];
            3'd2:    digit_column = glyph[23:16];
            3'd3:    digit_column = glyph[31:24];
            3'd4:    digit_column = glyph[39:32];
            default: digit_column = 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> src/mono_page_framebuffer_draw_unit.sv
// Page-mode monochrome framebuffer with pixel, rectangle, digit, clear and read actions.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: drawing fields, s_tuser: action
//  m_       out  m_tvalid/m_tready  m_tdata: read_byte
//
// Items are worked one at a time against a single-port byte store (registered read).
// Each is accepted, worked, then loaded into the output register. Work: pixel or
// rectangle a read-modify-write per covered byte (columns x pages), read byte a
// read and capture, digit its glyph columns, clear all STORE_BYTES (1024) bytes;
// clipped-away items none. After reset a clearing pass over all STORE_BYTES bytes
// runs with s_tready low. A new item is taken while the previous result waits in
// the output register; a finished item waits only if that register is still full.
`default_nettype none
module mono_page_framebuffer_draw_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] x_pos, [15:8] y_pos, [23:16] rect_width, [31:24] rect_height,
    // [32] pixel_on, [40:33] page_index, [48:41] char_code, [58:49] byte_index
    input  wire logic [63:0] s_tdata,
    // [2:0] action
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] read_byte
    output logic [7:0]       m_tdata
);

    localparam int AW = mpfd_pkg::ADDR_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_RRD  = 3'd2;
    localparam logic [2:0] ST_RWR  = 3'd3;
    localparam logic [2:0] ST_GLY  = 3'd4;
    localparam logic [2:0] ST_BRD  = 3'd5;
    localparam logic [2:0] ST_BWT  = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0]    state_reg;
    logic [7:0]    x_reg;
    logic [7:0]    y_reg;
    logic [8:0]    x_end_reg;
    logic [8:0]    y_end_reg;
    logic [4:0]    page_reg;
    logic [4:0]    page_end_reg;
    logic [7:0]    col_reg;
    logic [2:0]    gcol_reg;
    logic [3:0]    digit_reg;
    logic          on_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [7:0]    result_reg;
    logic          m_valid_reg;
    logic [7:0]    m_data_reg;
    logic          answer_clr_reg;

    logic [7:0]    mem [mpfd_pkg::STORE_BYTES];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    // unpacked input fields
    logic [7:0] in_x, in_y, in_w, in_h, in_page, in_code;
    logic       in_on;
    logic [9:0] in_bidx;
    logic [2:0] in_act;
    logic       s_fire;
    logic       out_load;

    assign in_x    = s_tdata[7:0];
    assign in_y    = s_tdata[15:8];
    assign in_w    = s_tdata[23:16];
    assign in_h    = s_tdata[31:24];
    assign in_on   = s_tdata[32];
    assign in_page = s_tdata[40:33];
    assign in_code = s_tdata[48:41];
    assign in_bidx = s_tdata[58:49];
    assign in_act  = s_tuser;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);

    // rectangle extent, clipped; a pixel is a 1x1 rectangle
    logic [8:0] span_w, span_h, x_end_raw, y_end_raw, x_end_c, y_end_c, y_last;
    logic       rect_empty;

    always_comb begin
        span_w    = (in_act == mpfd_pkg::ACT_PIXEL) ? 9'd1 : {1'b0, in_w};
        span_h    = (in_act == mpfd_pkg::ACT_PIXEL) ? 9'd1 : {1'b0, in_h};
        x_end_raw = {1'b0, in_x} + span_w;
        y_end_raw = {1'b0, in_y} + span_h;
        x_end_c   = (x_end_raw > 9'(mpfd_pkg::DISPLAY_WIDTH))
                    ? 9'(mpfd_pkg::DISPLAY_WIDTH) : x_end_raw;
        y_end_c   = (y_end_raw > 9'(mpfd_pkg::DISPLAY_HEIGHT))
                    ? 9'(mpfd_pkg::DISPLAY_HEIGHT) : y_end_raw;
        rect_empty = ({1'b0, in_x} >= x_end_c) || ({1'b0, in_y} >= y_end_c);
        y_last    = y_end_c - 9'd1;
    end

    logic digit_ok, read_ok;
    assign digit_ok = (in_code >= mpfd_pkg::CODE_ZERO) && (in_code <= mpfd_pkg::CODE_NINE)
                      && (32'(in_page) < mpfd_pkg::PAGE_COUNT);
    assign read_ok  = 32'(in_bidx) < mpfd_pkg::STORE_BYTES;

    // row mask of the current page inside the rectangle
    logic [7:0] row_mask;
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            row_mask[i] = ({1'b0, page_reg, 3'(i)} >= {1'b0, y_reg})
                          && ({1'b0, page_reg, 3'(i)} < y_end_reg);
        end
    end

    logic [8:0] glyph_col;
    logic       glyph_col_ok;
    logic [8:0] col_inc;
    logic       col_last;
    assign glyph_col    = {1'b0, x_reg} + {6'b0, gcol_reg};
    assign glyph_col_ok = glyph_col < 9'(mpfd_pkg::DISPLAY_WIDTH);
    assign col_inc      = {1'b0, col_reg} + 9'd1;
    assign col_last     = (col_inc == x_end_reg);

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = AW'(32'(page_reg) * mpfd_pkg::DISPLAY_WIDTH + 32'(col_reg));
        mem_wdata = on_reg ? (mem_rdata_reg | row_mask) : (mem_rdata_reg & ~row_mask);
        case (state_reg)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = 8'h00;
            end
            ST_RRD: mem_re = 1'b1;
            ST_RWR: mem_we = 1'b1;
            ST_GLY: begin
                mem_we    = glyph_col_ok;
                mem_addr  = AW'(32'(page_reg) * mpfd_pkg::DISPLAY_WIDTH + 32'(glyph_col[7:0]));
                mem_wdata = mpfd_pkg::digit_column(digit_reg, gcol_reg);
            end
            ST_BRD: begin
                mem_re   = 1'b1;
                mem_addr = rd_addr_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLR;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
            answer_clr_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        answer_clr_reg <= 1'b1;
                        result_reg     <= 8'h00;
                        x_reg          <= in_x;
                        y_reg          <= in_y;
                        x_end_reg      <= x_end_c;
                        y_end_reg      <= y_end_c;
                        on_reg         <= in_on;
                        col_reg        <= in_x;
                        page_reg       <= (in_act == mpfd_pkg::ACT_DIGIT)
                                          ? in_page[4:0] : in_y[7:3];
                        page_end_reg   <= y_last[7:3];
                        gcol_reg       <= 3'd0;
                        digit_reg      <= 4'(in_code - mpfd_pkg::CODE_ZERO);
                        rd_addr_reg    <= AW'(in_bidx);
                        clr_addr_reg   <= '0;
                        case (in_act)
                            mpfd_pkg::ACT_PIXEL,
                            mpfd_pkg::ACT_RECT:  state_reg <= rect_empty ? ST_FIN : ST_RRD;
                            mpfd_pkg::ACT_DIGIT: state_reg <= digit_ok ? ST_GLY : ST_FIN;
                            mpfd_pkg::ACT_CLEAR: state_reg <= ST_CLR;
                            mpfd_pkg::ACT_READ:  state_reg <= read_ok ? ST_BRD : ST_FIN;
                            default:             state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_CLR: begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(mpfd_pkg::STORE_BYTES - 1)) begin
                        // the pass after reset has no item to answer
                        state_reg <= answer_clr_reg ? ST_FIN : ST_IDLE;
                    end
                end
                ST_RRD: state_reg <= ST_RWR;
                ST_RWR: begin
                    if (col_last) begin
                        col_reg <= x_reg;
                        page_reg <= page_reg + 5'd1;
                        state_reg <= (page_reg == page_end_reg) ? ST_FIN : ST_RRD;
                    end else begin
                        col_reg   <= col_inc[7:0];
                        state_reg <= ST_RRD;
                    end
                end
                ST_GLY: begin
                    gcol_reg <= gcol_reg + 3'd1;
                    if (gcol_reg == 3'(mpfd_pkg::GLYPH_COLS - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_BRD: state_reg <= ST_BWT;
                ST_BWT: begin
                    result_reg <= mem_rdata_reg;
                    state_reg  <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_load) begin
                        m_data_reg <= result_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/mono_page_framebuffer_draw_checker.sv
// Port-level checks for the framebuffer draw unit, bound to the top level.
`default_nettype none
module mono_page_framebuffer_draw_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    logic [1:0] pending_reg;
    logic       s_fire, m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
        end else if (s_fire && !m_fire) begin
            pending_reg <= pending_reg + 2'd1;
        end else if (m_fire && !s_fire) begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    // the clearing pass holds off input right after reset
    a_clear_after_reset: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready during clearing pass");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second item taken while one is at work");

    a_result_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pending_reg != 2'd0))
        else $error("result without an accepted item");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two items outstanding");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind mono_page_framebuffer_draw_unit mono_page_framebuffer_draw_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
